>>> design/base64_line_wrapped_encoder_defines.svh
// Assertion macros shared by the base64 line-wrapped encoder RTL.
`ifndef BASE64_LINE_WRAPPED_ENCODER_DEFINES_SVH
`define BASE64_LINE_WRAPPED_ENCODER_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define B64LW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every clock edge, reset included.
`define B64LW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/b64lw_pkg.sv
// Types, constants and the sextet alphabet for the base64 line-wrapped encoder.
package b64lw_pkg;

  localparam logic [7:0] NEWLINE_CHAR     = 8'h0A;
  localparam logic [7:0] PAD_CHAR         = 8'h3D;
  localparam logic [7:0] MIN_LINE         = 8'd4;
  localparam logic [7:0] LINE_CHARS_RESET = 8'd75;
  localparam logic [7:0] COLUMN_MAX       = 8'd255;
  localparam int         MAX_RESULTS      = 7;
  localparam int         MAX_CHARS        = 4;

  typedef logic [7:0] char_t;
  typedef logic [$clog2(MAX_RESULTS+1)-1:0] res_cnt_t;

  function automatic char_t sextet_to_ascii(input logic [5:0] s);
    char_t c;
    if (s < 6'd26) begin
      c = 8'h41 + {2'b00, s};
    end else if (s < 6'd52) begin
      c = 8'h61 + {2'b00, s - 6'd26};
    end else if (s < 6'd62) begin
      c = 8'h30 + {2'b00, s - 6'd52};
    end else if (s == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

>>> design/base64_line_wrapped_encoder.sv
// Base64 encoder with line wrapping; the top level of the block.
//
// Input channel: in_valid/in_ready carry one message byte (in_data_byte) with
// in_has_byte and in_last. A transfer with in_has_byte low and in_last high
// ends a message without a byte; one with both low does nothing.
// Output channel: out_valid/out_ready carry one ASCII character per transfer
// in out_char, with out_last_char high on the closing newline of a message.
// cfg_wr_en/cfg_wr_data write line_chars (reset 75); the user must write it
// only while idle, which the block itself does not enforce. An accepted item
// is worked out combinationally and registered into a result buffer of up to
// seven characters; its first character is offered the next cycle and the
// rest follow one per cycle while out_ready is high. A new item is taken when
// the buffer is empty or its last character is transferred in the same cycle.
// When the receiver stalls, the buffer holds and in_ready stays low.
// Reset empties the buffer and returns group, carry and column state to zero.
module base64_line_wrapped_encoder
  import b64lw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_has_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last_char,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

`include "base64_line_wrapped_encoder_defines.svh"

  logic [7:0] line_chars_r;
  logic [1:0] group_phase_r, group_phase_nxt;
  logic [3:0] carry_bits_r, carry_bits_nxt;
  logic [7:0] line_column_r, line_column_nxt;
  logic       any_written_r, any_written_nxt;

  char_t      buf_char_r [MAX_RESULTS];
  logic       buf_last_r [MAX_RESULTS];
  res_cnt_t   cnt_r;

  char_t      res_char [MAX_RESULTS];
  logic       res_last [MAX_RESULTS];
  res_cnt_t   res_cnt;

  logic       accept;
  logic       pop;

  assign out_valid     = (cnt_r != '0);
  assign out_char      = buf_char_r[0];
  assign out_last_char = buf_last_r[0];
  assign pop           = out_valid && out_ready;
  assign in_ready      = (cnt_r == '0) || ((cnt_r == res_cnt_t'(1)) && out_ready);
  assign accept        = in_valid && in_ready;

  always_comb begin
    char_t      seq [MAX_CHARS];
    logic [2:0] nseq;
    logic [1:0] ph;
    logic [3:0] cb;
    logic [7:0] col;
    logic [7:0] limit;
    logic       aw;
    res_cnt_t   idx;

    for (int i = 0; i < MAX_CHARS; i++) begin
      seq[i] = PAD_CHAR;
    end
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res_char[i] = NEWLINE_CHAR;
      res_last[i] = 1'b0;
    end
    nseq  = 3'd0;
    ph    = group_phase_r;
    cb    = carry_bits_r;
    col   = line_column_r;
    aw    = any_written_r;
    idx   = '0;
    limit = (line_chars_r < MIN_LINE) ? MIN_LINE : line_chars_r;

    if (in_has_byte) begin
      case (ph)
        2'd0: begin
          seq[0] = sextet_to_ascii(in_data_byte[7:2]);
          nseq   = 3'd1;
          cb     = {2'b00, in_data_byte[1:0]};
          ph     = 2'd1;
        end
        2'd1: begin
          seq[0] = sextet_to_ascii({cb[1:0], in_data_byte[7:4]});
          nseq   = 3'd1;
          cb     = in_data_byte[3:0];
          ph     = 2'd2;
        end
        default: begin
          seq[0] = sextet_to_ascii({cb, in_data_byte[7:6]});
          seq[1] = sextet_to_ascii(in_data_byte[5:0]);
          nseq   = 3'd2;
          cb     = 4'd0;
          ph     = 2'd0;
        end
      endcase
    end

    if (in_last) begin
      if (ph == 2'd1) begin
        seq[nseq[1:0]]        = sextet_to_ascii({cb[1:0], 4'b0000});
        seq[nseq[1:0] + 2'd1] = PAD_CHAR;
        seq[nseq[1:0] + 2'd2] = PAD_CHAR;
        nseq                  = nseq + 3'd3;
      end else if (ph == 2'd2) begin
        seq[nseq[1:0]]        = sextet_to_ascii({cb, 2'b00});
        seq[nseq[1:0] + 2'd1] = PAD_CHAR;
        nseq                  = nseq + 3'd2;
      end
    end

    for (int i = 0; i < MAX_CHARS; i++) begin
      if (3'(i) < nseq) begin
        if (col >= limit) begin
          res_char[idx] = NEWLINE_CHAR;
          idx           = idx + res_cnt_t'(1);
          col           = 8'd0;
        end
        res_char[idx] = seq[i];
        idx           = idx + res_cnt_t'(1);
        if (col != COLUMN_MAX) begin
          col = col + 8'd1;
        end
        aw = 1'b1;
      end
    end

    if (in_last) begin
      if (aw) begin
        res_char[idx] = NEWLINE_CHAR;
        idx           = idx + res_cnt_t'(1);
      end
      res_char[idx] = NEWLINE_CHAR;
      res_last[idx] = 1'b1;
      idx           = idx + res_cnt_t'(1);
      ph            = 2'd0;
      cb            = 4'd0;
      col           = 8'd0;
      aw            = 1'b0;
    end

    res_cnt         = idx;
    group_phase_nxt = ph;
    carry_bits_nxt  = cb;
    line_column_nxt = col;
    any_written_nxt = aw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_chars_r  <= LINE_CHARS_RESET;
      group_phase_r <= 2'd0;
      carry_bits_r  <= 4'd0;
      line_column_r <= 8'd0;
      any_written_r <= 1'b0;
      cnt_r         <= '0;
    end else begin
      if (cfg_wr_en) begin
        line_chars_r <= cfg_wr_data;
      end
      if (accept) begin
        group_phase_r <= group_phase_nxt;
        carry_bits_r  <= carry_bits_nxt;
        line_column_r <= line_column_nxt;
        any_written_r <= any_written_nxt;
        cnt_r         <= res_cnt;
      end else if (pop) begin
        cnt_r <= cnt_r - res_cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        buf_char_r[i] <= res_char[i];
        buf_last_r[i] <= res_last[i];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        buf_char_r[i] <= buf_char_r[i+1];
        buf_last_r[i] <= buf_last_r[i+1];
      end
    end
  end

  `B64LW_ASSERT(a_ready_only_when_draining, in_ready |-> (cnt_r <= res_cnt_t'(1)), "in_ready with more than one buffered result")
  `B64LW_ASSERT(a_last_is_newline, (out_valid && out_last_char) |-> (out_char == NEWLINE_CHAR), "closing character is not a newline")
  `B64LW_ASSERT(a_end_clears_state, (in_valid && in_ready && in_last) |=> ((group_phase_r == 2'd0) && (line_column_r == 8'd0) && !any_written_r), "state not cleared after message end")
  `B64LW_ASSERT(a_end_yields_output, (in_valid && in_ready && in_last) |=> out_valid, "message end produced no result")
  `B64LW_ASSERT(a_phase_range, group_phase_r != 2'd3, "group phase out of range")
  `B64LW_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid, "buffer not empty after reset")

endmodule
